// ----- rtl/sd_spi_init_sequencer_assert.svh -----
// assertion macros for the sd spi init sequencer
`ifndef SD_SPI_INIT_SEQUENCER_ASSERT_SVH
`define SD_SPI_INIT_SEQUENCER_ASSERT_SVH

// clocked assertion, disabled while reset is asserted
`define SDSPI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form on top of the clocked assertion
`define SDSPI_ASSERT_IMP(label, ante, cons, msg) \
  `SDSPI_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ----- rtl/sdspi_pkg.sv -----
// types, codes and command frame tables for the sd spi init sequencer
`timescale 1ns / 1ps

package sdspi_pkg;

  // sequencer phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_DUMMY = 6'b000010,
    PH_FRAME = 6'b000100,
    PH_POLL  = 6'b001000,
    PH_TRAIL = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_e;

  // command steps of the bring-up sequence
  typedef enum logic [2:0] {
    STEP_CMD0   = 3'd0,
    STEP_CMD8   = 3'd1,
    STEP_CMD55  = 3'd2,
    STEP_ACMD41 = 3'd3,
    STEP_CMD58  = 3'd4
  } step_e;

  // run status codes
  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_READY     = 3'd1,
    ST_NORESP    = 3'd2,
    ST_BADIDLE   = 3'd3,
    ST_BADECHO   = 3'd4,
    ST_CMD58ERR  = 3'd5,
    ST_EXHAUSTED = 3'd6
  } status_e;

  // request kinds on the cmd field
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_POLL_LIMIT  = 2'd0;
  localparam logic [1:0] REG_DUMMY_BYTES = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT = 2'd2;

  localparam logic [7:0]  FILL_BYTE      = 8'hFF;
  localparam logic [7:0]  CMD_START      = 8'h40;
  localparam logic [7:0]  R1_IDLE        = 8'h01;
  localparam logic [7:0]  R1_READY       = 8'h00;
  localparam logic [7:0]  ECHO_VOLTAGE   = 8'h01;
  localparam logic [7:0]  ECHO_PATTERN   = 8'hAA;
  localparam logic [7:0]  FRAME_BYTES    = 8'd6;
  localparam logic [7:0]  TRAIL_BYTES    = 8'd4;
  localparam logic [7:0]  POLL_LIMIT_RST = 8'd10;
  localparam logic [7:0]  DUMMY_RST      = 8'd10;

  // command index per step
  function automatic logic [5:0] cmd_index(input step_e step);
    logic [5:0] idx;
    unique case (step)
      STEP_CMD0:   idx = 6'd0;
      STEP_CMD8:   idx = 6'd8;
      STEP_CMD55:  idx = 6'd55;
      STEP_ACMD41: idx = 6'd41;
      STEP_CMD58:  idx = 6'd58;
      default:     idx = 6'd0;
    endcase
    return idx;
  endfunction

  // command argument per step
  function automatic logic [31:0] cmd_arg(input step_e step);
    logic [31:0] arg;
    unique case (step)
      STEP_CMD8:   arg = 32'h0000_01AA;
      STEP_ACMD41: arg = 32'h4000_0000;
      default:     arg = 32'h0000_0000;
    endcase
    return arg;
  endfunction

  // crc byte per step, only cmd0 and cmd8 need a valid one
  function automatic logic [7:0] cmd_crc(input step_e step);
    logic [7:0] crc;
    unique case (step)
      STEP_CMD0: crc = 8'h95;
      STEP_CMD8: crc = 8'h87;
      default:   crc = 8'h01;
    endcase
    return crc;
  endfunction

  // commands that are followed by four trailing response bytes
  function automatic logic has_trailing(input step_e step);
    return (step == STEP_CMD8) || (step == STEP_CMD58);
  endfunction

  // byte k of the six-byte command frame
  function automatic logic [7:0] frame_byte(input step_e step, input logic [2:0] k);
    logic [31:0] arg;
    logic [7:0]  b;
    arg = cmd_arg(step);
    unique case (k)
      3'd0:    b = CMD_START | {2'b00, cmd_index(step)};
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = cmd_crc(step);
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/sd_spi_init_sequencer.sv -----
// sd card spi-mode bring-up sequencer, one byte exchange per request
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------------------
//   in       | input     | in_valid/in_ready  | cmd, rx_byte
//   out      | output    | out_valid/out_ready| tx_byte, exchange, select_high,
//            |           |                    | done_res, status, fast_clock
//   cfg      | input     | cfg_we             | cfg_idx, cfg_wdata
//
// a request is held in an input register, evaluated by the sequencer logic and
// written to the result register. one request per cycle is sustained while
// out_ready is high; the input register refills in the same cycle its request
// moves on to the result register.
// a stalled result register holds the input register, which then holds in_ready low.
// reset is asynchronous active low and leaves the sequencer idle with default limits.
`timescale 1ns / 1ps
`include "sd_spi_init_sequencer_assert.svh"

module sd_spi_init_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] rx_byte_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] tx_byte_o,
  output logic       exchange_o,
  output logic       select_high_o,
  output logic       done_res_o,
  output logic [2:0] status_o,
  output logic       fast_clock_o,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  // configuration registers
  logic [7:0]  poll_limit_q;
  logic [7:0]  dummy_bytes_q;
  logic [15:0] retry_limit_q;

  // pipeline control
  logic       in_valid_q;
  logic       in_cmd_q;
  logic [7:0] in_rx_q;
  logic       out_valid_q;
  logic       out_adv;
  logic       fire;

  // sequencer state
  sdspi_pkg::phase_e  phase_q, phase_d;
  sdspi_pkg::step_e   step_q, step_d;
  sdspi_pkg::status_e end_st_q, end_st_d;
  logic [7:0]  byte_cnt_q, byte_cnt_d;
  logic [7:0]  poll_cnt_q, poll_cnt_d;
  logic [7:0]  r1_q, r1_d;
  logic [15:0] retry_q, retry_d;
  logic        fast_q, fast_d;
  logic [7:0]  trail_q [4];
  logic        trail_we;
  logic [1:0]  trail_idx;

  // result of the current request
  logic [7:0]         res_tx;
  logic               res_ex;
  logic               res_sel;
  logic               res_done;
  sdspi_pkg::status_e res_st;

  // decision helpers
  logic               complete;
  logic               begin_cmd;
  sdspi_pkg::step_e   begin_step;
  logic               fin;
  sdspi_pkg::status_e fin_st;
  logic [7:0]         r1_eff;
  logic [15:0]        retry_inc;

  // result registers
  logic [7:0]         tx_q;
  logic               ex_q;
  logic               sel_q;
  logic               done_q;
  sdspi_pkg::status_e st_q;
  logic               fast_out_q;

  // handshake
  assign out_adv    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && out_adv;
  assign in_ready_o = !in_valid_q || out_adv;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q  <= sdspi_pkg::POLL_LIMIT_RST;
      dummy_bytes_q <= sdspi_pkg::DUMMY_RST;
      retry_limit_q <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdspi_pkg::REG_POLL_LIMIT:  poll_limit_q  <= cfg_wdata_i[7:0];
        sdspi_pkg::REG_DUMMY_BYTES: dummy_bytes_q <= cfg_wdata_i[7:0];
        sdspi_pkg::REG_RETRY_LIMIT: retry_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_cmd_q <= cmd_i;
      in_rx_q  <= rx_byte_i;
    end
  end

  // sequencer next state and result
  always_comb begin
    phase_d    = phase_q;
    step_d     = step_q;
    end_st_d   = end_st_q;
    byte_cnt_d = byte_cnt_q;
    poll_cnt_d = poll_cnt_q;
    r1_d       = r1_q;
    retry_d    = retry_q;
    fast_d     = fast_q;
    trail_we   = 1'b0;
    trail_idx  = byte_cnt_q[1:0] - 2'd1;
    res_tx     = sdspi_pkg::FILL_BYTE;
    res_ex     = 1'b0;
    res_sel    = 1'b1;
    res_done   = 1'b0;
    res_st     = sdspi_pkg::ST_BUSY;
    complete   = 1'b0;
    begin_cmd  = 1'b0;
    begin_step = sdspi_pkg::STEP_CMD0;
    fin        = 1'b0;
    fin_st     = sdspi_pkg::ST_BUSY;
    r1_eff     = r1_q;
    retry_inc  = retry_q + 16'd1;

    if (in_cmd_q == sdspi_pkg::REQ_START) begin
      // start request restarts the run
      phase_d    = sdspi_pkg::PH_DUMMY;
      step_d     = sdspi_pkg::STEP_CMD0;
      byte_cnt_d = 8'd1;
      poll_cnt_d = 8'd0;
      r1_d       = sdspi_pkg::FILL_BYTE;
      retry_d    = 16'd0;
      fast_d     = 1'b0;
      end_st_d   = sdspi_pkg::ST_BUSY;
      res_ex     = 1'b1;
    end else begin
      unique case (phase_q)
        sdspi_pkg::PH_DUMMY: begin
          if (byte_cnt_q < dummy_bytes_q) begin
            byte_cnt_d = byte_cnt_q + 8'd1;
            res_ex     = 1'b1;
          end else begin
            begin_cmd  = 1'b1;
            begin_step = sdspi_pkg::STEP_CMD0;
          end
        end
        sdspi_pkg::PH_FRAME: begin
          res_ex  = 1'b1;
          res_sel = 1'b0;
          if (byte_cnt_q < sdspi_pkg::FRAME_BYTES) begin
            res_tx     = sdspi_pkg::frame_byte(step_q, byte_cnt_q[2:0]);
            byte_cnt_d = byte_cnt_q + 8'd1;
          end else begin
            phase_d    = sdspi_pkg::PH_POLL;
            poll_cnt_d = 8'd1;
          end
        end
        sdspi_pkg::PH_POLL: begin
          if (!in_rx_q[7]) begin
            // r1 arrived
            r1_d   = in_rx_q;
            r1_eff = in_rx_q;
            if (sdspi_pkg::has_trailing(step_q)) begin
              phase_d    = sdspi_pkg::PH_TRAIL;
              byte_cnt_d = 8'd1;
              res_ex     = 1'b1;
              res_sel    = 1'b0;
            end else begin
              complete = 1'b1;
            end
          end else if (poll_cnt_q < poll_limit_q) begin
            poll_cnt_d = poll_cnt_q + 8'd1;
            res_ex     = 1'b1;
            res_sel    = 1'b0;
          end else begin
            fin    = 1'b1;
            fin_st = sdspi_pkg::ST_NORESP;
          end
        end
        sdspi_pkg::PH_TRAIL: begin
          trail_we = 1'b1;
          if (byte_cnt_q < sdspi_pkg::TRAIL_BYTES) begin
            byte_cnt_d = byte_cnt_q + 8'd1;
            res_ex     = 1'b1;
            res_sel    = 1'b0;
          end else begin
            complete = 1'b1;
          end
        end
        sdspi_pkg::PH_DONE: begin
          res_done = 1'b1;
          res_st   = end_st_q;
        end
        default: ;
      endcase
    end

    // command completion: check the response and choose the next command
    if (complete) begin
      unique case (step_q)
        sdspi_pkg::STEP_CMD0: begin
          if (r1_eff != sdspi_pkg::R1_IDLE) begin
            fin    = 1'b1;
            fin_st = sdspi_pkg::ST_BADIDLE;
          end else begin
            begin_cmd  = 1'b1;
            begin_step = sdspi_pkg::STEP_CMD8;
          end
        end
        sdspi_pkg::STEP_CMD8: begin
          // last echo byte is the one arriving now
          if (r1_eff != sdspi_pkg::R1_IDLE) begin
            fin    = 1'b1;
            fin_st = sdspi_pkg::ST_BADIDLE;
          end else if (trail_q[2] != sdspi_pkg::ECHO_VOLTAGE ||
                       in_rx_q != sdspi_pkg::ECHO_PATTERN) begin
            fin    = 1'b1;
            fin_st = sdspi_pkg::ST_BADECHO;
          end else begin
            begin_cmd  = 1'b1;
            begin_step = sdspi_pkg::STEP_CMD55;
          end
        end
        sdspi_pkg::STEP_CMD55: begin
          begin_cmd  = 1'b1;
          begin_step = sdspi_pkg::STEP_ACMD41;
        end
        sdspi_pkg::STEP_ACMD41: begin
          if (r1_eff == sdspi_pkg::R1_READY) begin
            begin_cmd  = 1'b1;
            begin_step = sdspi_pkg::STEP_CMD58;
          end else begin
            retry_d = retry_inc;
            if (retry_limit_q != 16'd0 && retry_inc >= retry_limit_q) begin
              fin    = 1'b1;
              fin_st = sdspi_pkg::ST_EXHAUSTED;
            end else begin
              begin_cmd  = 1'b1;
              begin_step = sdspi_pkg::STEP_CMD55;
            end
          end
        end
        sdspi_pkg::STEP_CMD58: begin
          fin    = 1'b1;
          fin_st = (r1_eff != sdspi_pkg::R1_READY) ? sdspi_pkg::ST_CMD58ERR
                                                    : sdspi_pkg::ST_READY;
        end
        default: begin
          fin    = 1'b1;
          fin_st = sdspi_pkg::ST_BADIDLE;
        end
      endcase
    end

    // first byte of a new command frame
    if (begin_cmd) begin
      step_d     = begin_step;
      phase_d    = sdspi_pkg::PH_FRAME;
      byte_cnt_d = 8'd1;
      res_tx     = sdspi_pkg::frame_byte(begin_step, 3'd0);
      res_ex     = 1'b1;
      res_sel    = 1'b0;
    end

    // end of run
    if (fin) begin
      phase_d  = sdspi_pkg::PH_DONE;
      end_st_d = fin_st;
      fast_d   = (fin_st == sdspi_pkg::ST_READY);
      res_tx   = sdspi_pkg::FILL_BYTE;
      res_ex   = 1'b0;
      res_sel  = 1'b1;
      res_done = 1'b1;
      res_st   = fin_st;
    end
  end

  // sequencer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= sdspi_pkg::PH_IDLE;
      step_q     <= sdspi_pkg::STEP_CMD0;
      end_st_q   <= sdspi_pkg::ST_BUSY;
      byte_cnt_q <= 8'd0;
      poll_cnt_q <= 8'd0;
      r1_q       <= sdspi_pkg::FILL_BYTE;
      retry_q    <= 16'd0;
      fast_q     <= 1'b0;
    end else if (fire) begin
      phase_q    <= phase_d;
      step_q     <= step_d;
      end_st_q   <= end_st_d;
      byte_cnt_q <= byte_cnt_d;
      poll_cnt_q <= poll_cnt_d;
      r1_q       <= r1_d;
      retry_q    <= retry_d;
      fast_q     <= fast_d;
    end
  end

  // trailing response bytes
  always_ff @(posedge clk_i) begin
    if (fire && (in_cmd_q == sdspi_pkg::REQ_BYTE) && trail_we) begin
      trail_q[trail_idx] <= in_rx_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      tx_q       <= res_tx;
      ex_q       <= res_ex;
      sel_q      <= res_sel;
      done_q     <= res_done;
      st_q       <= res_st;
      fast_out_q <= fast_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tx_byte_o     = tx_q;
  assign exchange_o    = ex_q;
  assign select_high_o = sel_q;
  assign done_res_o    = done_q;
  assign status_o      = st_q;
  assign fast_clock_o  = fast_out_q;

  // checks on result consistency
  `SDSPI_ASSERT_IMP(a_fast_only_when_ready, out_valid_o && fast_clock_o,
    done_res_o && status_o == sdspi_pkg::ST_READY, "fast clock without a ready card")
  `SDSPI_ASSERT_IMP(a_idle_bus_deselected, out_valid_o && !exchange_o,
    select_high_o, "card selected without an exchange")
  `SDSPI_ASSERT_IMP(a_done_is_final, out_valid_o && done_res_o,
    !exchange_o && status_o != sdspi_pkg::ST_BUSY, "finished run still busy or exchanging")

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the sd spi init sequencer with its own sequence predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;

  // one request: start or byte back from the card
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx;
  } req_t;

  // one exchange decision of the sequencer
  typedef struct packed {
    logic [7:0]         tx;
    logic               ex;
    logic               sel;
    logic               done;
    sdspi_pkg::status_e st;
    logic               fast;
  } reply_t;

  // sequencer state plus its limits
  typedef struct packed {
    sdspi_pkg::phase_e  ph;
    sdspi_pkg::step_e   step;
    logic [7:0]         cnt;
    logic [7:0]         polls;
    logic [7:0]         r1;
    logic [3:0][7:0]    trail;
    logic [15:0]        rounds;
    logic               fast;
    sdspi_pkg::status_e end_st;
    logic [7:0]         poll_lim;
    logic [7:0]         dummy_n;
    logic [15:0]        retry_lim;
  } seq_state_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        cmd_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  tx_byte_o;
  logic        exchange_o;
  logic        select_high_o;
  logic        done_res_o;
  logic [2:0]  status_o;
  logic        fast_clock_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  req_t       req_q[$];
  reply_t     want_replies[$];
  seq_state_t host_seq;
  seq_state_t plan_seq;
  logic       mute_card;
  int         send_idle_pct;
  int         stall_pct;
  int         hold_reqs;
  int         holds_done;
  int         hold_left;
  int         mismatches;
  int         cycles;

  sd_spi_init_sequencer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .tx_byte_o    (tx_byte_o),
    .exchange_o   (exchange_o),
    .select_high_o(select_high_o),
    .done_res_o   (done_res_o),
    .status_o     (status_o),
    .fast_clock_o (fast_clock_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // sequence predictor

  function automatic seq_state_t fresh_seq();
    seq_state_t s;
    s.ph        = sdspi_pkg::PH_IDLE;
    s.step      = sdspi_pkg::STEP_CMD0;
    s.cnt       = '0;
    s.polls     = '0;
    s.r1        = sdspi_pkg::FILL_BYTE;
    s.trail     = '0;
    s.rounds    = '0;
    s.fast      = 1'b0;
    s.end_st    = sdspi_pkg::ST_BUSY;
    s.poll_lim  = sdspi_pkg::POLL_LIMIT_RST;
    s.dummy_n   = sdspi_pkg::DUMMY_RST;
    s.retry_lim = '0;
    return s;
  endfunction

  function automatic void apply_reg(inout seq_state_t s, input logic [1:0] idx,
                                    input logic [15:0] val);
    case (idx)
      sdspi_pkg::REG_POLL_LIMIT:  s.poll_lim = val[7:0];
      sdspi_pkg::REG_DUMMY_BYTES: s.dummy_n = val[7:0];
      sdspi_pkg::REG_RETRY_LIMIT: s.retry_lim = val;
      default: ;
    endcase
  endfunction

  // byte k of a command frame: start+index, argument msb first, crc
  function automatic logic [7:0] cmd_frame_byte(input sdspi_pkg::step_e step,
                                                input logic [7:0] k);
    logic [7:0]  idx;
    logic [31:0] arg;
    logic [7:0]  crc;
    idx = 8'd0;
    arg = 32'h0000_0000;
    crc = 8'h01;
    case (step)
      sdspi_pkg::STEP_CMD0: begin
        crc = 8'h95;
      end
      sdspi_pkg::STEP_CMD8: begin
        idx = 8'd8;
        arg = 32'h0000_01AA;
        crc = 8'h87;
      end
      sdspi_pkg::STEP_CMD55:  idx = 8'd55;
      sdspi_pkg::STEP_ACMD41: begin
        idx = 8'd41;
        arg = 32'h4000_0000;
      end
      sdspi_pkg::STEP_CMD58:  idx = 8'd58;
      default: ;
    endcase
    if (k == 8'd0) return sdspi_pkg::CMD_START | idx;
    if (k <= 8'd4) return arg[8 * (4 - k) +: 8];
    return crc;
  endfunction

  function automatic reply_t seq_reply(input seq_state_t s, input logic [7:0] tx,
                                       input logic ex, input logic sel, input logic done,
                                       input sdspi_pkg::status_e st);
    reply_t r;
    r.tx   = tx;
    r.ex   = ex;
    r.sel  = sel;
    r.done = done;
    r.st   = st;
    r.fast = s.fast;
    return r;
  endfunction

  function automatic reply_t begin_cmd(inout seq_state_t s, input sdspi_pkg::step_e step);
    s.step = step;
    s.ph   = sdspi_pkg::PH_FRAME;
    s.cnt  = 8'd1;
    return seq_reply(s, cmd_frame_byte(step, 8'd0), 1'b1, 1'b0, 1'b0, sdspi_pkg::ST_BUSY);
  endfunction

  function automatic reply_t end_run(inout seq_state_t s, input sdspi_pkg::status_e st);
    s.ph     = sdspi_pkg::PH_DONE;
    s.end_st = st;
    s.fast   = (st == sdspi_pkg::ST_READY);
    return seq_reply(s, sdspi_pkg::FILL_BYTE, 1'b0, 1'b1, 1'b1, st);
  endfunction

  // decide what follows a command once its response is complete
  function automatic reply_t close_cmd(inout seq_state_t s);
    case (s.step)
      sdspi_pkg::STEP_CMD0: begin
        if (s.r1 != sdspi_pkg::R1_IDLE) return end_run(s, sdspi_pkg::ST_BADIDLE);
        return begin_cmd(s, sdspi_pkg::STEP_CMD8);
      end
      sdspi_pkg::STEP_CMD8: begin
        if (s.r1 != sdspi_pkg::R1_IDLE) return end_run(s, sdspi_pkg::ST_BADIDLE);
        if (s.trail[2] != sdspi_pkg::ECHO_VOLTAGE || s.trail[3] != sdspi_pkg::ECHO_PATTERN)
          return end_run(s, sdspi_pkg::ST_BADECHO);
        return begin_cmd(s, sdspi_pkg::STEP_CMD55);
      end
      sdspi_pkg::STEP_CMD55: return begin_cmd(s, sdspi_pkg::STEP_ACMD41);
      sdspi_pkg::STEP_ACMD41: begin
        if (s.r1 == sdspi_pkg::R1_READY) return begin_cmd(s, sdspi_pkg::STEP_CMD58);
        s.rounds = s.rounds + 16'd1;
        if (s.retry_lim != 16'd0 && s.rounds >= s.retry_lim)
          return end_run(s, sdspi_pkg::ST_EXHAUSTED);
        return begin_cmd(s, sdspi_pkg::STEP_CMD55);
      end
      sdspi_pkg::STEP_CMD58: begin
        if (s.r1 != sdspi_pkg::R1_READY) return end_run(s, sdspi_pkg::ST_CMD58ERR);
        return end_run(s, sdspi_pkg::ST_READY);
      end
      default: return end_run(s, sdspi_pkg::ST_BADIDLE);
    endcase
  endfunction

  // one request in, one exchange decision out
  function automatic reply_t next_exchange(inout seq_state_t s, input logic cmd,
                                           input logic [7:0] rx);
    reply_t r;
    if (cmd == sdspi_pkg::REQ_START) begin
      s.ph     = sdspi_pkg::PH_DUMMY;
      s.step   = sdspi_pkg::STEP_CMD0;
      s.cnt    = 8'd1;
      s.polls  = 8'd0;
      s.r1     = sdspi_pkg::FILL_BYTE;
      s.rounds = 16'd0;
      s.fast   = 1'b0;
      s.end_st = sdspi_pkg::ST_BUSY;
      return seq_reply(s, sdspi_pkg::FILL_BYTE, 1'b1, 1'b1, 1'b0, sdspi_pkg::ST_BUSY);
    end
    case (s.ph)
      sdspi_pkg::PH_DUMMY: begin
        if (s.cnt < s.dummy_n) begin
          s.cnt = s.cnt + 8'd1;
          return seq_reply(s, sdspi_pkg::FILL_BYTE, 1'b1, 1'b1, 1'b0, sdspi_pkg::ST_BUSY);
        end
        return begin_cmd(s, sdspi_pkg::STEP_CMD0);
      end
      sdspi_pkg::PH_FRAME: begin
        if (s.cnt < sdspi_pkg::FRAME_BYTES) begin
          r = seq_reply(s, cmd_frame_byte(s.step, s.cnt), 1'b1, 1'b0, 1'b0,
                        sdspi_pkg::ST_BUSY);
          s.cnt = s.cnt + 8'd1;
          return r;
        end
        s.ph    = sdspi_pkg::PH_POLL;
        s.polls = 8'd1;
        return seq_reply(s, sdspi_pkg::FILL_BYTE, 1'b1, 1'b0, 1'b0, sdspi_pkg::ST_BUSY);
      end
      sdspi_pkg::PH_POLL: begin
        if (!rx[7]) begin
          s.r1 = rx;
          if (s.step == sdspi_pkg::STEP_CMD8 || s.step == sdspi_pkg::STEP_CMD58) begin
            s.ph  = sdspi_pkg::PH_TRAIL;
            s.cnt = 8'd1;
            return seq_reply(s, sdspi_pkg::FILL_BYTE, 1'b1, 1'b0, 1'b0, sdspi_pkg::ST_BUSY);
          end
          return close_cmd(s);
        end
        if (s.polls < s.poll_lim) begin
          s.polls = s.polls + 8'd1;
          return seq_reply(s, sdspi_pkg::FILL_BYTE, 1'b1, 1'b0, 1'b0, sdspi_pkg::ST_BUSY);
        end
        return end_run(s, sdspi_pkg::ST_NORESP);
      end
      sdspi_pkg::PH_TRAIL: begin
        s.trail[s.cnt[1:0] - 2'd1] = rx;
        if (s.cnt < sdspi_pkg::TRAIL_BYTES) begin
          s.cnt = s.cnt + 8'd1;
          return seq_reply(s, sdspi_pkg::FILL_BYTE, 1'b1, 1'b0, 1'b0, sdspi_pkg::ST_BUSY);
        end
        return close_cmd(s);
      end
      sdspi_pkg::PH_DONE:
        return seq_reply(s, sdspi_pkg::FILL_BYTE, 1'b0, 1'b1, 1'b1, s.end_st);
      default: return seq_reply(s, sdspi_pkg::FILL_BYTE, 1'b0, 1'b1, 1'b0, sdspi_pkg::ST_BUSY);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // card emulation for the stimulus, steered by a planning copy of the state

  function automatic logic [7:0] card_byte(input seq_state_t s, input logic mute);
    logic [7:0] noise;
    int         roll;
    noise = 8'($urandom_range(255));
    roll  = $urandom_range(99);
    case (s.ph)
      sdspi_pkg::PH_POLL: begin
        // fill bytes first, then an r1 that is mostly the one the host hopes for
        if (mute || roll < 35) return noise | 8'h80;
        roll = $urandom_range(99);
        case (s.step)
          sdspi_pkg::STEP_CMD0, sdspi_pkg::STEP_CMD8:
            return (roll < 90) ? sdspi_pkg::R1_IDLE : (noise & 8'h7F);
          sdspi_pkg::STEP_ACMD41:
            return (roll < 50) ? sdspi_pkg::R1_IDLE :
                   (roll < 90) ? sdspi_pkg::R1_READY : (noise & 8'h7F);
          sdspi_pkg::STEP_CMD58:
            return (roll < 90) ? sdspi_pkg::R1_READY : (noise & 8'h7F);
          default: return noise & 8'h7F;
        endcase
      end
      sdspi_pkg::PH_TRAIL: begin
        // cmd8 echo of voltage and check pattern
        if (s.step == sdspi_pkg::STEP_CMD8 && roll < 92) begin
          if (s.cnt == 8'd3) return sdspi_pkg::ECHO_VOLTAGE;
          if (s.cnt == 8'd4) return sdspi_pkg::ECHO_PATTERN;
        end
        return noise;
      end
      default: return noise;
    endcase
  endfunction

  task automatic push_req(input logic c, input logic [7:0] b);
    req_t r;
    r.cmd = c;
    r.rx  = b;
    req_q.push_back(r);
    void'(next_exchange(plan_seq, c, b));
    if (c == sdspi_pkg::REQ_START) mute_card = ($urandom_range(99) < 4);
  endtask

  // mostly well-formed runs, with stray bytes and abandoned runs mixed in
  task automatic queue_reqs(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      if (plan_seq.ph == sdspi_pkg::PH_IDLE || plan_seq.ph == sdspi_pkg::PH_DONE)
        push_req(($urandom_range(99) < 75) ? sdspi_pkg::REQ_START : sdspi_pkg::REQ_BYTE,
                 8'($urandom_range(255)));
      else if ($urandom_range(199) == 0)
        push_req(sdspi_pkg::REQ_START, 8'($urandom_range(255)));
      else
        push_req(sdspi_pkg::REQ_BYTE, card_byte(plan_seq, mute_card));
    end
  endtask

  // settled values between edges: nothing queued, offered or awaiting its result
  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_q.size() != 0 || in_valid_i || want_replies.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(host_seq, idx, val);
    apply_reg(plan_seq, idx, val);
  endtask

  task automatic run_phase(input logic [15:0] poll, input logic [15:0] dummy,
                           input logic [15:0] retry, input int idle_pct, input int stall,
                           input int count, input bit hold, input bit pause);
    write_reg(sdspi_pkg::REG_POLL_LIMIT, poll);
    write_reg(sdspi_pkg::REG_DUMMY_BYTES, dummy);
    write_reg(sdspi_pkg::REG_RETRY_LIMIT, retry);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    if (hold) hold_reqs++;
    if (pause) begin
      queue_reqs(count / 2);
      wait_drained();
      queue_reqs(count - count / 2);
    end else begin
      queue_reqs(count);
    end
    wait_drained();
  endtask

  task automatic report_error(input string what, input logic [7:0] got,
                              input logic [7:0] want);
    $display("tb_top: %s got 'h%0h, expected 'h%0h, cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // clock, cycle limit

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // request driver
  always @(posedge clk_i) begin : drive_req
    req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_q.pop_front();
        in_valid_i <= 1'b1;
        cmd_i      <= nxt.cmd;
        rx_byte_i  <= nxt.rx;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with random stalls and long hold-offs on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_reqs != holds_done) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: check results against the oldest prediction, predict accepted requests
  always @(posedge clk_i) begin : watch
    reply_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (want_replies.size() == 0) begin
          report_error("result with nothing pending, tx_byte", tx_byte_o, 8'h00);
        end else begin
          want = want_replies.pop_front();
          if (tx_byte_o !== want.tx) report_error("tx_byte", tx_byte_o, want.tx);
          if (exchange_o !== want.ex)
            report_error("exchange", 8'(exchange_o), 8'(want.ex));
          if (select_high_o !== want.sel)
            report_error("select_high", 8'(select_high_o), 8'(want.sel));
          if (done_res_o !== want.done)
            report_error("done_res", 8'(done_res_o), 8'(want.done));
          if (status_o !== want.st)
            report_error("status", 8'(status_o), 8'(want.st));
          if (fast_clock_o !== want.fast)
            report_error("fast_clock", 8'(fast_clock_o), 8'(want.fast));
        end
      end
      if (in_valid_i && in_ready_o)
        want_replies.push_back(next_exchange(host_seq, cmd_i, rx_byte_i));
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence

  initial begin
    rst_ni      <= 1'b0;
    cmd_i       <= sdspi_pkg::REQ_START;
    rx_byte_i   <= 8'h00;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= 2'd0;
    cfg_wdata_i <= 16'h0000;
    host_seq      = fresh_seq();
    plan_seq      = fresh_seq();
    mute_card     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_reqs     = 0;
    holds_done    = 0;
    hold_left     = 0;
    mismatches    = 0;
    cycles        = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero poll and dummy limits behave as one
    write_reg(sdspi_pkg::REG_POLL_LIMIT, 16'd0);
    write_reg(sdspi_pkg::REG_DUMMY_BYTES, 16'd0);
    write_reg(sdspi_pkg::REG_RETRY_LIMIT, 16'd1);
    // bytes before any start
    push_req(sdspi_pkg::REQ_BYTE, 8'h00);
    push_req(sdspi_pkg::REQ_BYTE, 8'hFF);
    // start, single dummy, full cmd0 frame, into polling
    push_req(sdspi_pkg::REQ_START, 8'hFF);
    repeat (7) push_req(sdspi_pkg::REQ_BYTE, sdspi_pkg::FILL_BYTE);
    // no response within one poll byte
    push_req(sdspi_pkg::REQ_BYTE, 8'hFF);
    // byte after finish repeats the final status
    push_req(sdspi_pkg::REQ_BYTE, 8'h00);
    // start, then a start again in the middle of the cmd0 frame
    push_req(sdspi_pkg::REQ_START, 8'h00);
    repeat (3) push_req(sdspi_pkg::REQ_BYTE, 8'h00);
    push_req(sdspi_pkg::REQ_START, 8'h5A);
    wait_drained();

    // no idling, default limits
    run_phase(16'd10, 16'd10, 16'd0, 0, 0, 250, 1'b0, 1'b0);
    // sender idle most cycles
    run_phase(16'd3, 16'd2, 16'd2, 81, 0, 250, 1'b0, 1'b0);
    // long receiver hold-off while requests keep coming, then heavy stalls
    run_phase(16'd1, 16'd1, 16'd1, 0, 81, 250, 1'b1, 1'b0);
    // largest limits, both sides idling
    run_phase(16'd255, 16'd255, 16'hFFFF, 20, 20, 280, 1'b0, 1'b0);
    // small random limits, sender pauses until all results are back
    run_phase(16'($urandom_range(6, 1)), 16'($urandom_range(12, 1)),
              16'($urandom_range(5, 0)), 0, 0, 250, 1'b0, 1'b1);

    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && want_replies.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
